/* design/npcs_pkg.sv */
// Shared types, codes and helpers for the nearest palette color search block.
package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int CHAN_W = 8;
    localparam int LANES  = 3;
    localparam int PROD_W = 2 * CHAN_W;
    // Largest distance is 3 * 255^2, which fits in 18 bits.
    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = '1;

    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;

    // Request kinds carried on s_tuser.
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_NEAREST = 2'd1;
    localparam logic [1:0] KIND_BLEND   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_BLEND_RED   = 2'd0;
    localparam logic [1:0] REG_BLEND_GREEN = 2'd1;
    localparam logic [1:0] REG_BLEND_BLUE  = 2'd2;
    localparam logic [1:0] REG_BLEND_ALPHA = 2'd3;

    // Multiplier lane operations.
    localparam logic [1:0] OP_SQ_DIFF   = 2'd0;
    localparam logic [1:0] OP_MIX_BLEND = 2'd1;
    localparam logic [1:0] OP_MIX_ENTRY = 2'd2;

    // Lane 2 red, lane 1 green, lane 0 blue.
    typedef logic [LANES-1:0][CHAN_W-1:0] rgb_t;
    typedef logic [LANES-1:0][PROD_W-1:0] prod_t;

    typedef struct packed {
        logic       en;
        logic [1:0] op;
    } unit_ctrl_t;

    // Exact floor(x / 255) for any x up to 255 * 255, the largest 8x8 product.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[PROD_W-1:CHAN_W]};
        return s[PROD_W-1:CHAN_W];
    endfunction

endpackage

/* design/npcs_palette.sv */
// Palette memory with per-entry valid bits and a registered read port.
module npcs_palette #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF,
    parameter int IDX_W = $clog2(PALETTE_ENTRIES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  npcs_pkg::rgb_t   wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output npcs_pkg::rgb_t   rd_data
);
    import npcs_pkg::*;

    rgb_t                       mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    rgb_t                       rd_mem_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    // Never-written entries read as black.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

/* design/npcs_mul_unit.sv */
// Three-lane 8x8 multiplier shared by the distance scan and the blend mix.
module npcs_mul_unit (
    input  logic                aclk,
    input  npcs_pkg::unit_ctrl_t ctrl,
    input  npcs_pkg::rgb_t      entry_rgb,
    input  npcs_pkg::rgb_t      target_rgb,
    input  npcs_pkg::rgb_t      blend_rgb,
    input  logic [7:0]          alpha,
    output npcs_pkg::prod_t     prod
);
    import npcs_pkg::*;

    prod_t prod_reg;

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        logic [CHAN_W-1:0] a_op;
        logic [CHAN_W-1:0] b_op;

        always_comb begin
            case (ctrl.op)
                OP_MIX_BLEND: begin
                    a_op = blend_rgb[c];
                    b_op = alpha;
                end
                OP_MIX_ENTRY: begin
                    a_op = target_rgb[c];
                    b_op = ALPHA_FULL - alpha;
                end
                default: begin
                    // Square of the absolute channel difference.
                    a_op = (target_rgb[c] >= entry_rgb[c]) ? target_rgb[c] - entry_rgb[c]
                                                           : entry_rgb[c] - target_rgb[c];
                    b_op = a_op;
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                prod_reg[c] <= a_op * b_op;
            end
        end
    end

    assign prod = prod_reg;

endmodule

/* design/nearest_palette_color_search.sv */
// Top level: palette store, request sequencer and nearest-entry scan.
//
// Requests arrive on the s_ stream; s_tuser carries the kind. A write
// stores one palette entry and is done in the cycle it is accepted (no
// result). A nearest request scans entries 0 to limit-1 (limit saturated to
// PALETTE_ENTRIES) and returns the index of the closest entry by squared
// Euclidean distance, lowest index on ties, with found = 0 for an empty
// scan. A blend request first mixes one stored entry with the blend color
// and alpha registers, then scans for the mixed color. Unused kinds are
// dropped. s_tready is high only while the sequencer is idle out of reset.
// The scan reads one palette word per cycle through the single memory
// read port. The result sits in an output register; a stalled m_tready
// holds it, and a following write may still be accepted, while a
// following query waits at its end until the register is free. Reset
// clears the palette to black (valid bits), the blend registers to zero
// and drops any result. Configuration must be written by the user through
// cfg_wr_en/cfg_index/cfg_wdata while idle; the block does not enforce it.
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24],
    // search_limit[40:32], zero pad[47:41]
    input  logic [47:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // color_index[7:0]
    output logic [7:0]  m_tdata,
    // found[0]
    output logic        m_tuser
);
    import npcs_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BLEND_A = 3'd1;
    localparam logic [2:0] ST_BLEND_B = 3'd2;
    localparam logic [2:0] ST_BLEND_C = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // Request fields
    logic [1:0]  in_kind;
    logic [7:0]  in_index;
    rgb_t        in_rgb;
    logic [8:0]  in_limit;
    logic        in_range;
    logic        accept;

    assign in_kind  = s_tuser;
    assign in_index = s_tdata[7:0];
    assign in_rgb   = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
    assign in_limit = s_tdata[40:32];
    assign in_range = {23'd0, in_index} < 31'(PALETTE_ENTRIES);

    // Configuration registers
    rgb_t       blend_rgb_reg;
    logic [7:0] alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_rgb_reg <= '0;
            alpha_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BLEND_RED:   blend_rgb_reg[2] <= cfg_wdata;
                REG_BLEND_GREEN: blend_rgb_reg[1] <= cfg_wdata;
                REG_BLEND_BLUE:  blend_rgb_reg[0] <= cfg_wdata;
                REG_BLEND_ALPHA: alpha_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and scan state
    logic [2:0]        state_reg,    state_next;
    rgb_t              target_reg,   target_next;
    logic [CNT_W-1:0]  limit_reg,    limit_next;
    logic [CNT_W-1:0]  rd_cnt_reg,   rd_cnt_next;
    logic              blend_oob_reg, blend_oob_next;
    logic              s1_vld_reg,   s1_vld_next;
    logic [IDX_W-1:0]  s1_idx_reg,   s1_idx_next;
    logic              s2_vld_reg,   s2_vld_next;
    logic [IDX_W-1:0]  s2_idx_reg,   s2_idx_next;
    logic [DIST_W-1:0] best_reg,     best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              found_reg,    found_next;
    logic              m_valid_reg,  m_valid_next;
    logic [7:0]        m_idx_reg,    m_idx_next;
    logic              m_found_reg,  m_found_next;

    // Palette and multiplier connections
    logic             pal_wr_en;
    logic             pal_rd_en;
    logic [IDX_W-1:0] pal_rd_addr;
    rgb_t             pal_rd_data;
    unit_ctrl_t       unit_ctrl;
    prod_t            prod;
    logic [DIST_W-1:0] dist_sum;
    logic             issue;

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign pal_wr_en = accept && (in_kind == KIND_WRITE) && in_range;
    assign issue     = (rd_cnt_reg < limit_reg);
    assign dist_sum  = DIST_W'(prod[0]) + DIST_W'(prod[1]) + DIST_W'(prod[2]);

    npcs_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .IDX_W          (IDX_W)
    ) u_palette (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (pal_wr_en),
        .wr_addr(in_index[IDX_W-1:0]),
        .wr_data(in_rgb),
        .rd_en  (pal_rd_en),
        .rd_addr(pal_rd_addr),
        .rd_data(pal_rd_data)
    );

    npcs_mul_unit u_mul (
        .aclk      (aclk),
        .ctrl      (unit_ctrl),
        .entry_rgb (pal_rd_data),
        .target_rgb(target_reg),
        .blend_rgb (blend_rgb_reg),
        .alpha     (alpha_reg),
        .prod      (prod)
    );

    always_comb begin
        state_next     = state_reg;
        target_next    = target_reg;
        limit_next     = limit_reg;
        rd_cnt_next    = rd_cnt_reg;
        blend_oob_next = blend_oob_reg;
        s1_vld_next    = 1'b0;
        s1_idx_next    = s1_idx_reg;
        s2_vld_next    = 1'b0;
        s2_idx_next    = s2_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_idx_next     = m_idx_reg;
        m_found_next   = m_found_reg;
        pal_rd_en      = 1'b0;
        pal_rd_addr    = rd_cnt_reg[IDX_W-1:0];
        unit_ctrl      = '{en: 1'b0, op: OP_SQ_DIFF};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_kind == KIND_NEAREST || in_kind == KIND_BLEND)) begin
                    // Saturate the limit to the palette size.
                    if ({23'd0, in_limit} > 32'(PALETTE_ENTRIES)) begin
                        limit_next = CNT_W'(PALETTE_ENTRIES);
                    end else begin
                        limit_next = CNT_W'(in_limit);
                    end
                    found_next    = (in_limit != '0);
                    rd_cnt_next   = '0;
                    best_next     = NO_MATCH_DIST;
                    best_idx_next = '0;
                    if (in_kind == KIND_NEAREST) begin
                        target_next = in_rgb;
                        state_next  = ST_SCAN;
                    end else begin
                        // Fetch the entry to blend; out-of-range blends black.
                        pal_rd_en      = 1'b1;
                        pal_rd_addr    = in_index[IDX_W-1:0];
                        blend_oob_next = !in_range;
                        state_next     = ST_BLEND_A;
                    end
                end
            end
            ST_BLEND_A: begin
                // blend * alpha into the product registers, hold the entry
                unit_ctrl   = '{en: 1'b1, op: OP_MIX_BLEND};
                target_next = blend_oob_reg ? '0 : pal_rd_data;
                state_next  = ST_BLEND_B;
            end
            ST_BLEND_B: begin
                // entry * (255 - alpha), keep the first quotient
                unit_ctrl = '{en: 1'b1, op: OP_MIX_ENTRY};
                for (int c = 0; c < LANES; c++) begin
                    target_next[c] = div255(prod[c]);
                end
                state_next = ST_BLEND_C;
            end
            ST_BLEND_C: begin
                // Sum of quotients never exceeds 255.
                for (int c = 0; c < LANES; c++) begin
                    target_next[c] = target_reg[c] + div255(prod[c]);
                end
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // Read stage: one palette address per cycle.
                if (issue) begin
                    pal_rd_en   = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    s1_vld_next = 1'b1;
                    s1_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                // Square stage.
                unit_ctrl   = '{en: s1_vld_reg, op: OP_SQ_DIFF};
                s2_vld_next = s1_vld_reg;
                s2_idx_next = s1_idx_reg;
                // Compare stage: strict less keeps the lowest index on ties.
                if (s2_vld_reg && dist_sum < best_reg) begin
                    best_next     = dist_sum;
                    best_idx_next = s2_idx_reg;
                end
                if (!issue && !s1_vld_reg && !s2_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold here until the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = 8'(best_idx_reg);
                    m_found_next = found_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg    <= target_next;
        limit_reg     <= limit_next;
        rd_cnt_reg    <= rd_cnt_next;
        blend_oob_reg <= blend_oob_next;
        s1_idx_reg    <= s1_idx_next;
        s2_idx_reg    <= s2_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        found_reg     <= found_next;
        m_idx_reg     <= m_idx_next;
        m_found_reg   <= m_found_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_idx_reg;
    assign m_tuser  = m_found_reg;

endmodule

/* tb/tb_nearest_palette_color_search.sv */
// Self-checking testbench for the nearest palette color search block.
module tb_nearest_palette_color_search;
    timeunit 1ns;
    timeprecision 1ps;
    import npcs_pkg::*;

    // Kind code that the block drops without a result
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int ENTRIES        = 256;
    // Longest scan is limit 256 plus blend overhead; round up generously
    localparam int DRAIN_CYCLES   = 300;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int BLEND_PHASES   = 6;
    localparam int REQS_PER_PHASE = 205;
    localparam int SCRIPT_LEN     = 23;
    localparam int REPORT_MAX     = 10;
    localparam int COLOR_HISTORY  = 64;

    typedef struct packed {
        logic [7:0] color_index;
        logic       found;
    } palette_hit_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] entry;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] limit;
        logic       typed;
        logic [7:0] typed_index;
        logic       typed_found;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    nearest_palette_color_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the palette and the blend registers
    logic [7:0] pal_red   [ENTRIES];
    logic [7:0] pal_green [ENTRIES];
    logic [7:0] pal_blue  [ENTRIES];
    logic [7:0] mix_red, mix_green, mix_blue, mix_alpha;

    palette_hit_t pending_hits[$];
    logic [23:0]  stored_colors[$];

    // A directed row may pin its expected result; sampled at the accepting edge
    logic         pin_valid;
    palette_hit_t pin_hit;

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int n_writes    = 0;
    int n_nearest   = 0;
    int n_blend     = 0;
    int n_dropped   = 0;
    int n_checked   = 0;
    int n_empty     = 0;
    int rx_mode     = 0;
    int rx_span     = 0;

    script_row_t script_rows [SCRIPT_LEN];

    // Scan entries 0..limit-1 for the smallest squared distance, first one wins ties
    function automatic palette_hit_t closest_entry(input logic [7:0] r, g, b,
                                                   input logic [8:0] limit);
        int unsigned best;
        int unsigned sq_dist;
        int          span;
        int          dr, dg, db;
        palette_hit_t hit;
        best = 32'h0fff_ffff;
        hit  = '0;
        span = (limit > ENTRIES) ? ENTRIES : int'(limit);
        for (int i = 0; i < span; i++) begin
            dr      = int'(r) - int'(pal_red[i]);
            dg      = int'(g) - int'(pal_green[i]);
            db      = int'(b) - int'(pal_blue[i]);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best) begin
                best            = sq_dist;
                hit.color_index = 8'(i);
                hit.found       = 1'b1;
            end
        end
        return hit;
    endfunction

    // Per-channel mix, each term divided by 255 on its own (truncating)
    function automatic logic [7:0] mix_channel(input logic [7:0] over, base, alpha);
        int unsigned sum;
        sum = (int'(over) * int'(alpha)) / 255
            + (int'(base) * (255 - int'(alpha))) / 255;
        return 8'(sum);
    endfunction

    function automatic logic [7:0] pick_channel();
        logic [7:0] v;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: v = 8'd0;
                1: v = 8'd1;
                2: v = 8'd127;
                3: v = 8'd128;
                4: v = 8'd254;
                default: v = 8'd255;
            endcase
        end else begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input palette_hit_t want,
                                   input palette_hit_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected index %0d found %0b, got index %0d found %0b",
                     $time, what, want.color_index, want.found,
                     got.color_index, got.found);
    endtask

    // Track accepted requests and config writes, predict and check results
    always @(posedge aclk) begin
        palette_hit_t want;
        palette_hit_t got;
        logic [7:0]   ent;
        // Reset clears the palette to black and the blend registers to zero
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                pal_red[i]   = 8'd0;
                pal_green[i] = 8'd0;
                pal_blue[i]  = 8'd0;
            end
            mix_red   = 8'd0;
            mix_green = 8'd0;
            mix_blue  = 8'd0;
            mix_alpha = 8'd0;
        end
        if (aresetn && cfg_wr_en) begin
            case (cfg_index)
                REG_BLEND_RED:   mix_red   = cfg_wdata;
                REG_BLEND_GREEN: mix_green = cfg_wdata;
                REG_BLEND_BLUE:  mix_blue  = cfg_wdata;
                REG_BLEND_ALPHA: mix_alpha = cfg_wdata;
                default: ;
            endcase
        end
        if (aresetn && s_tvalid && s_tready) begin
            ent = s_tdata[7:0];
            case (s_tuser)
                KIND_WRITE: begin
                    pal_red[ent]   = s_tdata[15:8];
                    pal_green[ent] = s_tdata[23:16];
                    pal_blue[ent]  = s_tdata[31:24];
                    n_writes++;
                end
                KIND_NEAREST, KIND_BLEND: begin
                    if (s_tuser == KIND_NEAREST) begin
                        want = closest_entry(s_tdata[15:8], s_tdata[23:16],
                                             s_tdata[31:24], s_tdata[40:32]);
                        n_nearest++;
                    end else begin
                        want = closest_entry(mix_channel(mix_red, pal_red[ent], mix_alpha),
                                             mix_channel(mix_green, pal_green[ent], mix_alpha),
                                             mix_channel(mix_blue, pal_blue[ent], mix_alpha),
                                             s_tdata[40:32]);
                        n_blend++;
                    end
                    // Typed-in result overrides the prediction for pinned rows
                    if (pin_valid)
                        want = pin_hit;
                    if (!want.found)
                        n_empty++;
                    pending_hits.push_back(want);
                end
                default: n_dropped++;
            endcase
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.color_index = m_tdata;
            got.found       = m_tuser;
            if (pending_hits.size() == 0) begin
                report_mismatch("result with nothing expected", '0, got);
            end else begin
                want = pending_hits.pop_front();
                n_checked++;
                if (got.color_index !== want.color_index)
                    report_mismatch("color_index mismatch", want, got);
                else if (got.found !== want.found)
                    report_mismatch("found mismatch", want, got);
            end
        end
    end

    // Receiver: switch between always ready, coin-flip stalls and long stalls
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_span <= $urandom_range(50, 400);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_hits.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold the request until the block takes it
    task automatic send_request(input logic [1:0] kind, input logic [7:0] entry,
                                input logic [7:0] r, g, b, input logic [8:0] limit,
                                input logic pinned, input palette_hit_t want);
        s_tvalid  <= 1'b1;
        s_tuser   <= kind;
        s_tdata   <= {7'd0, limit, b, g, r, entry};
        pin_valid <= pinned;
        pin_hit   <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sender bursts: keep valid up for a run of requests, then drop it for a gap
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Pause until every result has come, then let any dropped request settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_blend(input logic [7:0] r, g, b, a);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BLEND_RED;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_index <= REG_BLEND_GREEN;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_index <= REG_BLEND_BLUE;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_index <= REG_BLEND_ALPHA;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_request();
        logic [1:0] kind;
        logic [7:0] entry, r, g, b;
        logic [8:0] limit;
        logic [23:0] rgb;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            kind = KIND_WRITE;
        else if (roll < 70)
            kind = KIND_NEAREST;
        else if (roll < 95)
            kind = KIND_BLEND;
        else
            kind = KIND_UNUSED;
        // Most traffic lands in the low entries that short scans reach
        entry = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 31));
        r = pick_channel();
        g = pick_channel();
        b = pick_channel();
        // Aim some searches at stored colors to hit exact matches and ties
        if (kind == KIND_NEAREST && stored_colors.size() > 0 && $urandom_range(0, 2) == 0) begin
            rgb = stored_colors[$urandom_range(0, stored_colors.size() - 1)];
            {r, g, b} = rgb;
            if ($urandom_range(0, 1) == 1)
                r = r ^ 8'd1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70)
            limit = 9'($urandom_range(0, 31));
        else if (roll < 90)
            limit = 9'($urandom_range(32, 255));
        else
            limit = 9'($urandom_range(256, 511));
        if (kind == KIND_WRITE) begin
            stored_colors.push_back({r, g, b});
            if (stored_colors.size() > COLOR_HISTORY)
                void'(stored_colors.pop_front());
        end
        send_request(kind, entry, r, g, b, limit, 1'b0, '0);
        pace();
    endtask

    initial begin
        palette_hit_t typed_hit;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_BLEND_RED;
        cfg_wdata <= 8'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_WRITE;
        pin_valid <= 1'b0;
        pin_hit   <= '0;

        // Directed part; runs on reset blend registers (alpha zero: entry passes through)
        script_rows = '{
            // black palette after reset: first entry wins, empty scan, blend of black
            '{KIND_NEAREST, 8'd0,   8'd255, 8'd255, 8'd255, 9'd256, 1'b1, 8'd0,   1'b1},
            '{KIND_NEAREST, 8'd0,   8'd9,   8'd9,   8'd9,   9'd0,   1'b1, 8'd0,   1'b0},
            '{KIND_BLEND,   8'd255, 8'd0,   8'd0,   8'd0,   9'd1,   1'b1, 8'd0,   1'b1},
            '{KIND_WRITE,   8'd0,   8'd255, 8'd255, 8'd255, 9'd0,   1'b0, 8'd0,   1'b0},
            '{KIND_WRITE,   8'd1,   8'd0,   8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   1'b0},
            '{KIND_WRITE,   8'd255, 8'd128, 8'd64,  8'd32,  9'd0,   1'b0, 8'd0,   1'b0},
            '{KIND_WRITE,   8'd2,   8'd255, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   1'b0},
            '{KIND_WRITE,   8'd3,   8'd0,   8'd255, 8'd0,   9'd0,   1'b0, 8'd0,   1'b0},
            '{KIND_WRITE,   8'd4,   8'd0,   8'd0,   8'd255, 9'd0,   1'b0, 8'd0,   1'b0},
            '{KIND_NEAREST, 8'd0,   8'd255, 8'd255, 8'd255, 9'd256, 1'b1, 8'd0,   1'b1},
            // limit far above the palette saturates
            '{KIND_NEAREST, 8'd0,   8'd0,   8'd0,   8'd0,   9'd511, 1'b1, 8'd1,   1'b1},
            '{KIND_NEAREST, 8'd0,   8'd0,   8'd0,   8'd0,   9'd1,   1'b1, 8'd0,   1'b1},
            '{KIND_NEAREST, 8'd0,   8'd250, 8'd5,   8'd5,   9'd256, 1'b1, 8'd2,   1'b1},
            '{KIND_NEAREST, 8'd0,   8'd128, 8'd64,  8'd32,  9'd256, 1'b1, 8'd255, 1'b1},
            '{KIND_NEAREST, 8'd0,   8'd128, 8'd64,  8'd32,  9'd255, 1'b0, 8'd0,   1'b0},
            '{KIND_BLEND,   8'd3,   8'd0,   8'd0,   8'd0,   9'd256, 1'b1, 8'd3,   1'b1},
            // unused kind with every data bit set: dropped, no result
            '{KIND_UNUSED,  8'd255, 8'd255, 8'd255, 8'd255, 9'd511, 1'b0, 8'd0,   1'b0},
            '{KIND_BLEND,   8'd4,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, 8'd0,   1'b0},
            '{KIND_NEAREST, 8'd0,   8'd128, 8'd64,  8'd32,  9'd257, 1'b1, 8'd255, 1'b1},
            '{KIND_WRITE,   8'd254, 8'd1,   8'd2,   8'd3,   9'd0,   1'b0, 8'd0,   1'b0},
            '{KIND_NEAREST, 8'd0,   8'd1,   8'd2,   8'd3,   9'd256, 1'b1, 8'd254, 1'b1},
            '{KIND_BLEND,   8'd254, 8'd0,   8'd0,   8'd0,   9'd300, 1'b1, 8'd254, 1'b1},
            '{KIND_NEAREST, 8'd255, 8'd255, 8'd255, 8'd255, 9'd511, 1'b1, 8'd0,   1'b1}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script_rows[i]) begin
            typed_hit.color_index = script_rows[i].typed_index;
            typed_hit.found       = script_rows[i].typed_found;
            send_request(script_rows[i].kind, script_rows[i].entry, script_rows[i].red,
                         script_rows[i].green, script_rows[i].blue, script_rows[i].limit,
                         script_rows[i].typed, typed_hit);
            pace();
        end

        // Random phases, each under its own blend setting, written while idle
        for (int phase = 0; phase < BLEND_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: set_blend(8'd255, 8'd255, 8'd255, ALPHA_FULL);
                1: set_blend(8'd0, 8'd0, 8'd0, 8'd0);
                2: set_blend(8'd255, 8'd0, 8'd128, 8'd128);
                3: set_blend(8'd0, 8'd255, 8'd0, 8'd1);
                default: set_blend(pick_channel(), pick_channel(), pick_channel(),
                                   pick_channel());
            endcase
            repeat (REQS_PER_PHASE) random_request();
        end

        wait_idle();
        if (pending_hits.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pending_hits.size());
        end

        $display("Covered %0d palette writes, %0d nearest and %0d blend searches, %0d dropped kinds.",
                 n_writes, n_nearest, n_blend, n_dropped);
        $display("Checked %0d results (%0d empty scans) over %0d blend settings, %0d mismatches.",
                 n_checked, n_empty, BLEND_PHASES, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* nearest_palette_color_search.f */
design/npcs_pkg.sv
design/npcs_palette.sv
design/npcs_mul_unit.sv
design/nearest_palette_color_search.sv
tb/tb_nearest_palette_color_search.sv
